>>> rtl/afu_pkg.sv
`default_nettype none

package afu_pkg;

    // Element format and stream widths.
    localparam int DATA_W = 16;
    localparam int FUNC_W = 2;
    localparam int MAG_W  = DATA_W + 1;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int CFG_W      = 16;

    localparam logic REG_LEAK_SLOPE = 1'b0;
    localparam logic REG_ELU_ALPHA  = 1'b1;

    localparam logic [CFG_W-1:0] LEAK_SLOPE_RST = 16'd655;
    localparam logic [CFG_W-1:0] ELU_ALPHA_RST  = 16'd256;

    // Activation selector codes carried on tuser.
    localparam logic [FUNC_W-1:0] FUNC_RELU  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LEAKY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ELU   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PASS  = 2'd3;

    // Exponential: |x| * log2(e) in Q24, then a power-of-two table.
    localparam int              LOG2E_W   = 17;
    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam int M_W         = MAG_W + LOG2E_W;
    localparam int FRAC_W      = 24;
    localparam int Q_W         = M_W - FRAC_W;
    localparam int EXP_ENTRIES = 32;
    localparam int EXP_IDX_W   = $clog2(EXP_ENTRIES);
    localparam int W_W         = FRAC_W - EXP_IDX_W;
    localparam int TAB_W       = 17;
    localparam int SH_W        = 5;
    localparam int SH_MAX      = (1 << SH_W) - 1;
    localparam int PROD_W      = TAB_W + W_W;
    localparam int EA_W        = CFG_W + TAB_W;

    localparam logic [TAB_W-1:0] ONE_Q16 = 17'h10000;
    localparam int               Q16_SH  = 16;

    // Stage count of the datapath, output register included.
    localparam int PIPE_STAGES = 6;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } t_pipe_ctl;

    typedef struct packed {
        logic [CFG_W-1:0] leak_slope;
        logic [CFG_W-1:0] elu_alpha;
    } t_cfg;

    // 2^(-k/32) in Q16, rounded to nearest, for k = 0 .. 32.
    function automatic logic [TAB_W-1:0] pow2_rom(input logic [EXP_IDX_W:0] k);
        logic [TAB_W-1:0] v;
        case (k)
            6'd0:    v = 17'd65536;
            6'd1:    v = 17'd64132;
            6'd2:    v = 17'd62757;
            6'd3:    v = 17'd61413;
            6'd4:    v = 17'd60097;
            6'd5:    v = 17'd58809;
            6'd6:    v = 17'd57549;
            6'd7:    v = 17'd56316;
            6'd8:    v = 17'd55109;
            6'd9:    v = 17'd53928;
            6'd10:   v = 17'd52773;
            6'd11:   v = 17'd51642;
            6'd12:   v = 17'd50535;
            6'd13:   v = 17'd49452;
            6'd14:   v = 17'd48393;
            6'd15:   v = 17'd47356;
            6'd16:   v = 17'd46341;
            6'd17:   v = 17'd45348;
            6'd18:   v = 17'd44376;
            6'd19:   v = 17'd43425;
            6'd20:   v = 17'd42495;
            6'd21:   v = 17'd41584;
            6'd22:   v = 17'd40693;
            6'd23:   v = 17'd39821;
            6'd24:   v = 17'd38968;
            6'd25:   v = 17'd38133;
            6'd26:   v = 17'd37316;
            6'd27:   v = 17'd36516;
            6'd28:   v = 17'd35734;
            6'd29:   v = 17'd34968;
            6'd30:   v = 17'd34219;
            6'd31:   v = 17'd33486;
            6'd32:   v = 17'd32768;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/activation_function_unit.sv
// Activation function unit: ReLU, LeakyReLU and ELU on signed Q8.8 elements.
//
// Input stream: s_axis_tdata carries the element, s_axis_tuser the function
// selector (0 ReLU, 1 LeakyReLU, 2 ELU, 3 pass-through) and s_axis_tlast the
// end-of-tensor flag. The output stream returns the activated, saturated
// element with the same tlast. Non-negative elements pass unchanged.
// The APB port holds the LeakyReLU slope (Q0.16, offset 0x0, reset 655) and
// the ELU alpha (Q8.8, offset 0x4, reset 256); write them only while idle.
//
// An accepted input beat reaches the output through the stages of the
// exponential path: scale, table lookup, interpolation multiply, shift,
// alpha multiply and the output register. One beat is taken every cycle
// while a stage is free. When the output is stalled the pipeline keeps
// accepting beats until every stage is full, then drops s_axis_tready;
// nothing is lost or repeated. Reset (synchronous, active low) empties the
// pipeline and restores the register defaults.
`default_nettype none

module activation_function_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [afu_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire  [afu_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [afu_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [afu_pkg::DATA_W-1:0]            s_axis_tdata,  // [15:0] x_value
    input  wire  [afu_pkg::FUNC_W-1:0]            s_axis_tuser,  // [1:0] func
    input  wire                                   s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [afu_pkg::DATA_W-1:0]            m_axis_tdata,  // [15:0] y_value
    output logic                                  m_axis_tlast
);
    import afu_pkg::*;

    localparam int SB_LAST = PIPE_STAGES - 2;
    localparam int LPROD_W = MAG_W + CFG_W;

    t_cfg      cfg;
    t_pipe_ctl ctl;

    logic [DATA_W-1:0] r_x    [0:SB_LAST];
    logic [FUNC_W-1:0] r_func [0:SB_LAST];
    logic              r_neg  [0:SB_LAST];
    logic              r_last [0:SB_LAST];
    logic [MAG_W-1:0]  r_lmag [1:SB_LAST];
    logic [LPROD_W-1:0] r_lprod;
    logic [EA_W-1:0]   r_ea;
    logic [DATA_W-1:0] r_y;
    logic              r_tlast;

    logic [MAG_W-1:0]   in_mag;
    logic [TAB_W-1:0]   exp_e;
    logic [LPROD_W:0]   lprod_up;
    logic [EA_W:0]      ea_up;
    logic [MAG_W-1:0]   emag;
    logic [MAG_W-1:0]   nmag;
    logic [DATA_W-1:0]  n_y;

    afu_csr u_csr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    afu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_ctl       (ctl)
    );

    // Magnitude of a negative element; the value of -2^15 needs the extra bit.
    assign in_mag = MAG_W'(0) - {s_axis_tdata[DATA_W-1], s_axis_tdata};

    afu_exp u_exp (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_mag (in_mag),
        .o_e   (exp_e)
    );

    // Negated results round toward minus infinity, so magnitudes round up.
    assign lprod_up = {1'b0, r_lprod} + (LPROD_W+1)'((1 << Q16_SH) - 1);
    assign ea_up    = {1'b0, r_ea} + (EA_W+1)'((1 << Q16_SH) - 1);
    assign emag     = ea_up[Q16_SH +: MAG_W];

    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_x[0]    <= s_axis_tdata;
            r_func[0] <= s_axis_tuser;
            r_neg[0]  <= s_axis_tdata[DATA_W-1];
            r_last[0] <= s_axis_tlast;
            r_lprod   <= in_mag * cfg.leak_slope;
        end
        for (int k = 1; k <= SB_LAST; k++) begin
            if (ctl.load[k]) begin
                r_x[k]    <= r_x[k-1];
                r_func[k] <= r_func[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
        if (ctl.load[1]) begin
            r_lmag[1] <= lprod_up[Q16_SH +: MAG_W];
        end
        for (int k = 2; k <= SB_LAST; k++) begin
            if (ctl.load[k]) begin
                r_lmag[k] <= r_lmag[k-1];
            end
        end
        if (ctl.load[4]) begin
            r_ea <= cfg.elu_alpha * (ONE_Q16 - exp_e);
        end
        if (ctl.load[PIPE_STAGES-1]) begin
            r_y     <= n_y;
            r_tlast <= r_last[SB_LAST];
        end
    end

    always_comb begin
        case (r_func[SB_LAST])
            FUNC_RELU:  nmag = '0;
            FUNC_LEAKY: nmag = r_lmag[SB_LAST];
            FUNC_ELU:   nmag = emag;
            default:    nmag = '0;
        endcase
        if (!r_neg[SB_LAST] || r_func[SB_LAST] == FUNC_PASS) begin
            n_y = r_x[SB_LAST];
        end else if (nmag > MAG_W'(1 << (DATA_W - 1))) begin
            // Saturate at the most negative code.
            n_y = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_y = DATA_W'(MAG_W'(0) - nmag);
        end
    end

    assign m_axis_tvalid = ctl.valid[PIPE_STAGES-1];
    assign m_axis_tdata  = r_y;
    assign m_axis_tlast  = r_tlast;

endmodule

`default_nettype wire

>>> rtl/afu_csr.sv
`default_nettype none

module afu_csr (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [afu_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [afu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [afu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output afu_pkg::t_cfg                    o_cfg
);
    import afu_pkg::*;

    logic [CFG_W-1:0] r_leak_slope;
    logic [CFG_W-1:0] r_elu_alpha;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers sit on a four-byte pitch, so bit 2 picks the register.
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_slope <= LEAK_SLOPE_RST;
            r_elu_alpha  <= ELU_ALPHA_RST;
        end else if (wr_en) begin
            if (reg_sel == REG_LEAK_SLOPE) begin
                r_leak_slope <= pwdata[CFG_W-1:0];
            end else begin
                r_elu_alpha <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_ELU_ALPHA) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_elu_alpha};
        end else begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, r_leak_slope};
        end
    end

    assign o_cfg.leak_slope = r_leak_slope;
    assign o_cfg.elu_alpha  = r_elu_alpha;

endmodule

`default_nettype wire

>>> rtl/afu_ctrl.sv
`default_nettype none

module afu_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_out_ready,
    output logic                 o_in_ready,
    output afu_pkg::t_pipe_ctl   o_ctl
);
    import afu_pkg::*;

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES:0]   rdy;
    logic [PIPE_STAGES-1:0] load;

    // A stage may take a new beat when it is empty or its contents move on,
    // so bubbles are squeezed out while the output is stalled.
    always_comb begin
        rdy[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (k == 0) begin
                n_valid[k] = rdy[k] ? i_in_valid : r_valid[k];
                load[k]    = rdy[k] && i_in_valid;
            end else begin
                n_valid[k] = rdy[k] ? r_valid[k-1] : r_valid[k];
                load[k]    = rdy[k] && r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_ctl.load  = load;
    assign o_ctl.valid = r_valid;

endmodule

`default_nettype wire

>>> rtl/afu_exp.sv
`default_nettype none

module afu_exp (
    input  wire                          i_clk,
    input  afu_pkg::t_pipe_ctl           i_ctl,
    input  wire [afu_pkg::MAG_W-1:0]     i_mag,
    output logic [afu_pkg::TAB_W-1:0]    o_e
);
    import afu_pkg::*;

    // Stage 1: scale by log2(e).
    logic [M_W-1:0]       r_m;
    // Stage 2: table lookup.
    logic [TAB_W-1:0]     r_t0_2;
    logic [TAB_W-1:0]     r_d;
    logic [W_W-1:0]       r_w;
    logic [Q_W-1:0]       r_q2;
    // Stage 3: interpolation product.
    logic [PROD_W-1:0]    r_prod;
    logic [TAB_W-1:0]     r_t0_3;
    logic [Q_W-1:0]       r_q3;
    // Stage 4: integer part applied as a right shift.
    logic [TAB_W-1:0]     r_e;

    logic [EXP_IDX_W-1:0] idx;
    logic [EXP_IDX_W:0]   idx_next;
    logic [TAB_W-1:0]     t0;
    logic [TAB_W-1:0]     t1;
    logic [TAB_W-1:0]     p;

    assign idx      = r_m[FRAC_W-1 -: EXP_IDX_W];
    assign idx_next = {1'b0, idx} + 1'b1;
    assign t0       = pow2_rom({1'b0, idx});
    assign t1       = pow2_rom(idx_next);
    assign p        = r_t0_3 - r_prod[PROD_W-1:W_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_m <= i_mag * LOG2E_Q16;
        end
        if (i_ctl.load[1]) begin
            r_t0_2 <= t0;
            r_d    <= t0 - t1;
            r_w    <= r_m[W_W-1:0];
            r_q2   <= r_m[M_W-1:FRAC_W];
        end
        if (i_ctl.load[2]) begin
            r_prod <= r_d * r_w;
            r_t0_3 <= r_t0_2;
            r_q3   <= r_q2;
        end
        if (i_ctl.load[3]) begin
            // Beyond 31 halvings the power of two is below one LSB.
            if (r_q3 > Q_W'(SH_MAX)) begin
                r_e <= '0;
            end else begin
                r_e <= p >> r_q3[SH_W-1:0];
            end
        end
    end

    assign o_e = r_e;

endmodule

`default_nettype wire

>>> rtl/afu_checker.sv
`default_nettype none

module afu_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              psel,
    input wire                              penable,
    input wire                              pwrite,
    input wire [afu_pkg::APB_ADDR_W-1:0]    paddr,
    input wire [afu_pkg::APB_DATA_W-1:0]    pwdata,
    input wire [afu_pkg::APB_DATA_W-1:0]    prdata,
    input wire                              pready,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [afu_pkg::DATA_W-1:0]        m_axis_tdata,
    input wire                              m_axis_tlast
);
    import afu_pkg::*;

    // A held output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // The input side only backs up when the output is stalled with data.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // A register reads back what was last written to it.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) ##1
            (psel && !pwrite && paddr[2] == $past(paddr[2])) |->
            prdata == {{(APB_DATA_W-CFG_W){1'b0}}, $past(pwdata[CFG_W-1:0])})
        else $error("register readback mismatch");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/tb_activation_function_unit.sv
`timescale 1ns / 100ps

module tb_activation_function_unit;

    import afu_pkg::*;

    localparam int               NEVER_QUIET   = 3000;
    localparam int               HOLD_CYCLES   = 200;
    localparam int               TABLE_SIZE    = 32;
    localparam longint unsigned  LOG2E_FIX     = 64'd94548;
    localparam longint unsigned  LN2_FIX       = 64'd2977044472;
    localparam logic [APB_ADDR_W-1:0] ADDR_LEAK  = {REG_LEAK_SLOPE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_ALPHA = {REG_ELU_ALPHA, 2'b00};

    typedef struct {
        logic [DATA_W-1:0] y_value;
        logic              last;
    } t_act_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;   // [15:0] x_value
    logic [FUNC_W-1:0]     s_axis_tuser;   // [1:0] func
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;   // [15:0] y_value
    logic                  m_axis_tlast;

    // Shadow copies of the two registers and the power-of-two table.
    logic [CFG_W-1:0]  slope_reg;
    logic [CFG_W-1:0]  alpha_reg;
    longint unsigned   pow2_q16 [0:TABLE_SIZE];

    t_act_result       pending_results [$];
    int unsigned       error_count;
    int unsigned       quiet_cycles = 0;
    bit                src_idle_on;
    bit                sink_idle_on;
    bit                sink_hold_req;
    logic [FUNC_W-1:0] func_kinds [4] = '{FUNC_RELU, FUNC_LEAKY, FUNC_ELU, FUNC_PASS};

    activation_function_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // 2^(-k/32) in Q16 from a twenty-one-term series of exp(-k*ln2/32) in Q32.
    function automatic longint unsigned pow2_series(int unsigned k);
        longint unsigned arg;
        longint unsigned term;
        longint          acc;
        logic [127:0]    prod;
        arg  = (LN2_FIX * k) / TABLE_SIZE;
        term = 64'd1 << 32;
        acc  = longint'(term);
        for (int n = 1; n <= 20; n++) begin
            prod = 128'(term) * 128'(arg);
            term = 64'(prod >> 32) / n;
            if (n % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        return (longint'(acc) + 32768) >>> 16;
    endfunction

    function automatic longint clamp_q88(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_act_result activate(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] x,
                                             logic last);
        t_act_result     res;
        longint          xs;
        longint          y;
        longint unsigned mag, m, q, r, s, idx, w, t0, t1, p, e;
        xs = longint'($signed(x));
        y  = xs;
        if (xs < 0) begin
            mag = longint'(0 - xs);
            case (f)
                FUNC_RELU:  y = 0;
                FUNC_LEAKY: y = 0 - longint'((mag * slope_reg + 65535) >> 16);
                FUNC_ELU: begin
                    // exp(x) = 2^-q * 2^-(r/2^24), the fraction from the table.
                    m   = mag * LOG2E_FIX;
                    q   = m >> 24;
                    r   = m & 64'hFF_FFFF;
                    s   = r * TABLE_SIZE;
                    idx = s >> 24;
                    w   = s & 64'hFF_FFFF;
                    t0  = pow2_q16[idx];
                    t1  = pow2_q16[idx + 1];
                    p   = t0 - (((t0 - t1) * w) >> 24);
                    e   = (q >= 32) ? 0 : (p >> q);
                    if (e > 65536) e = 65536;
                    y   = 0 - longint'((alpha_reg * (65536 - e) + 65535) >> 16);
                end
                default: ;
            endcase
        end
        res.y_value = DATA_W'(clamp_q88(y));
        res.last    = last;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_element(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] x, logic last);
        int unsigned gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = x;
        s_axis_tuser  = f;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(activate(f, x, last));
    endtask

    // Stops offering beats and lets the pipeline empty completely.
    task automatic drain_pipeline();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic program_reg(logic [APB_ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        drain_pipeline();
        apb_access(1'b1, addr, APB_DATA_W'(value), rd);
        if (addr == ADDR_LEAK) slope_reg = value;
        else                   alpha_reg = value;
        apb_access(1'b0, addr, '0, rd);
        if (rd != APB_DATA_W'(value))
            report_mismatch("register readback", longint'(rd), longint'(value));
    endtask

    function automatic logic [DATA_W-1:0] pick_x();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)  return DATA_W'($urandom);
        if (r < 8)  return DATA_W'(0 - $urandom_range(1, 3000));
        if (r == 8) return $urandom_range(0, 1) ? 16'h8000 : 16'hFFFF;
        return DATA_W'($urandom_range(0, 1024));
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 6)  return FUNC_RELU;
        if (r < 12) return FUNC_LEAKY;
        if (r < 19) return FUNC_ELU;
        return FUNC_PASS;
    endfunction

    task automatic test_directed_edges();
        foreach (func_kinds[k]) begin
            send_element(func_kinds[k], 16'h8000, 1'b0);
            send_element(func_kinds[k], 16'hFFFF, 1'b0);
            send_element(func_kinds[k], 16'h0000, 1'b0);
            send_element(func_kinds[k], 16'h7FFF, 1'b1);
        end
        // Around minus one, plus a small and a mid-range negative exponent.
        send_element(FUNC_ELU, 16'hFF00, 1'b0);
        send_element(FUNC_ELU, 16'hFC18, 1'b0);
        send_element(FUNC_ELU, 16'hF000, 1'b1);
        send_element(FUNC_LEAKY, 16'hFF00, 1'b0);
        send_element(FUNC_LEAKY, 16'hFFFE, 1'b1);
    endtask

    task automatic test_random_stream(int unsigned count, bit src_idle, bit sink_idle);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        repeat (count) send_element(pick_func(), pick_x(), $urandom_range(0, 7) == 0);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // The receiver stalls for a long stretch while beats keep coming, so that
    // every stage fills and the input is held off.
    task automatic test_output_backpressure();
        drain_pipeline();
        sink_hold_req = 1'b1;
        @(negedge i_clk);
        src_idle_on = 1'b0;
        repeat (40) send_element(pick_func(), pick_x(), $urandom_range(0, 7) == 0);
        src_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (15) send_element(pick_func(), pick_x(), 1'b0);
        drain_pipeline();
        repeat (15) send_element(pick_func(), pick_x(), $urandom_range(0, 1));
    endtask

    task automatic test_register_settings();
        program_reg(ADDR_LEAK, 16'h0000);
        program_reg(ADDR_ALPHA, 16'h0000);
        test_random_stream(150, 1'b0, 1'b0);
        program_reg(ADDR_LEAK, 16'hFFFF);
        program_reg(ADDR_ALPHA, 16'hFFFF);
        test_directed_edges();
        test_random_stream(150, 1'b1, 1'b1);
        repeat (2) begin
            program_reg(ADDR_LEAK, CFG_W'($urandom));
            program_reg(ADDR_ALPHA, CFG_W'($urandom_range(0, 1024)));
            test_random_stream(150, 1'b1, 1'b1);
        end
    endtask

    initial begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_RELU;
        s_axis_tlast  = 1'b0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        sink_hold_req = 1'b0;
        error_count   = 0;
        slope_reg     = LEAK_SLOPE_RST;
        alpha_reg     = ELU_ALPHA_RST;
        for (int k = 0; k <= TABLE_SIZE; k++) pow2_q16[k] = pow2_series(k);
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_edges();
        test_random_stream(100, 1'b1, 1'b1);
        test_output_backpressure();
        test_drain_pause();
        test_register_settings();

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[activation_function_unit] OK");
        end else begin
            $display("[activation_function_unit] ERROR");
        end
        $finish;
    end

    // Receiver: random stalls, mostly short, with the odd long one.
    initial begin
        int unsigned r;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                sink_hold_req = 1'b0;
                m_axis_tready = 1'b1;
            end else if (!sink_idle_on) begin
                m_axis_tready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready = 1'b1;
                end else if (r < 97) begin
                    m_axis_tready = 1'b0;
                end else begin
                    m_axis_tready = 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_act_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, y_value", longint'($signed(m_axis_tdata)), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata != want.y_value)
                    report_mismatch("y_value", longint'($signed(m_axis_tdata)),
                                    longint'($signed(want.y_value)));
                if (m_axis_tlast != want.last)
                    report_mismatch("tlast", longint'(m_axis_tlast), longint'(want.last));
            end
        end
    end

    // Watchdog: a long run of cycles with no beat and no register access.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= NEVER_QUIET) begin
            $display("[activation_function_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
